/* hw/rtl/srtf_pkg.sv */
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants of the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int TICK_W        = 32;
  localparam int BURST_W       = 16;
  localparam int SLOT_IN_W     = 3;
  localparam int QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic                 valid;
    logic [SLOT_IN_W-1:0] slot;
    logic [BURST_W-1:0]   burst;
    logic                 in_range;
  } item_t;

  typedef struct packed {
    logic [TICK_W-1:0]    tick_time;
    logic                 run_valid;
    logic [SLOT_IN_W-1:0] run_slot;
    logic                 done_valid;
    logic [SLOT_IN_W-1:0] done_slot;
    logic [TICK_W-1:0]    turnaround;
    logic [TICK_W-1:0]    wait_ticks;
    logic                 arrive_rejected;
  } res_t;

  typedef struct packed {
    logic [BURST_W-1:0] rem;
    logic [BURST_W-1:0] burst;
    logic [TICK_W-1:0]  arr;
  } slot_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_RET_RD,
    ST_RET_TURN,
    ST_RET_WAIT,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage

/* hw/rtl/srtf_ram.sv */
// ----------------------------------------------------------------------------
// srtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srtf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/srtf_fifo.sv */
// ----------------------------------------------------------------------------
// srtf_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module srtf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = srtf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/srtf_front.sv */
// ----------------------------------------------------------------------------
// srtf_front
// Input side: classify each tick item (slot range) and queue it for the core.
// ----------------------------------------------------------------------------
module srtf_front #(
  parameter int NUM_SLOTS = srtf_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic                           arrive_valid,
  input  logic [srtf_pkg::SLOT_IN_W-1:0] arrive_slot,
  input  logic [srtf_pkg::BURST_W-1:0]   arrive_burst,
  input  logic                           pop,
  output logic                           empty,
  output srtf_pkg::item_t                item
);

  srtf_pkg::item_t                      item_in;
  logic [$bits(srtf_pkg::item_t)-1:0]   q_rd;

  always_comb begin
    item_in.valid    = arrive_valid;
    item_in.slot     = arrive_slot;
    item_in.burst    = arrive_burst;
    item_in.in_range = (32'(arrive_slot) < 32'(NUM_SLOTS));
  end

  srtf_fifo #(
    .WIDTH ($bits(srtf_pkg::item_t)),
    .DEPTH (srtf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (item_in),
    .full    (full),
    .pop     (pop),
    .rd_data (q_rd),
    .empty   (empty)
  );

  assign item = q_rd;

endmodule

/* hw/rtl/srtf_back.sv */
// ----------------------------------------------------------------------------
// srtf_back
// Scheduler core: load arrival, retire the finished task, scan the slot table
// one slot per cycle for the least remaining time, then run the chosen task.
// ----------------------------------------------------------------------------
module srtf_back #(
  parameter int NUM_SLOTS = srtf_pkg::NUM_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_empty,
  input  srtf_pkg::item_t in_item,
  output logic            in_pop,
  input  logic            out_full,
  output logic            out_push,
  output srtf_pkg::res_t  out_res
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int EXT_W  = SLOT_W + srtf_pkg::SLOT_IN_W;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int REC_W  = $bits(srtf_pkg::slot_rec_t);

  srtf_pkg::state_t    state_r, state_nxt;
  logic [srtf_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic                run_vld_r, run_vld_nxt;
  logic [SLOT_W-1:0]   run_slot_r, run_slot_nxt;
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]   cmp_slot_r, cmp_slot_nxt;
  logic [CNT_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  srtf_pkg::item_t     item_r, item_nxt;
  logic                rej_r, rej_nxt;
  logic                done_vld_r, done_vld_nxt;
  logic [SLOT_W-1:0]   done_slot_r, done_slot_nxt;
  logic [srtf_pkg::TICK_W-1:0] turn_r, turn_nxt;
  logic [srtf_pkg::TICK_W-1:0] wait_r, wait_nxt;
  logic                found_r, found_nxt;
  logic [SLOT_W-1:0]   best_slot_r, best_slot_nxt;
  srtf_pkg::slot_rec_t best_rec_r, best_rec_nxt;

  logic                ram_we, ram_re;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  srtf_pkg::slot_rec_t ram_wrec, rd_rec;
  logic [REC_W-1:0]    ram_rdata;

  logic [EXT_W-1:0]    arr_ext;
  logic [SLOT_W-1:0]   arr_slot;
  logic                arr_ok;
  logic [EXT_W-1:0]    run_ext, done_ext;

  assign rd_rec   = ram_rdata;
  assign arr_ext  = EXT_W'(item_r.slot);
  assign arr_slot = arr_ext[SLOT_W-1:0];
  assign arr_ok   = item_r.valid && item_r.in_range && !active_r[arr_slot];

  srtf_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrec),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srtf_pkg::ST_IDLE: begin
        if (!in_empty) begin
          state_nxt = srtf_pkg::ST_ARRIVE;
        end
      end
      srtf_pkg::ST_ARRIVE: begin
        if (run_vld_r && active_r[run_slot_r]) begin
          state_nxt = srtf_pkg::ST_RET_RD;
        end else begin
          state_nxt = srtf_pkg::ST_SCAN;
        end
      end
      srtf_pkg::ST_RET_RD: begin
        state_nxt = srtf_pkg::ST_RET_TURN;
      end
      srtf_pkg::ST_RET_TURN: begin
        if (rd_rec.rem == '0) begin
          state_nxt = srtf_pkg::ST_RET_WAIT;
        end else begin
          state_nxt = srtf_pkg::ST_SCAN;
        end
      end
      srtf_pkg::ST_RET_WAIT: begin
        state_nxt = srtf_pkg::ST_SCAN;
      end
      srtf_pkg::ST_SCAN: begin
        if (scan_cnt_r == CNT_W'(NUM_SLOTS)) begin
          state_nxt = srtf_pkg::ST_UPDATE;
        end
      end
      srtf_pkg::ST_UPDATE: begin
        state_nxt = srtf_pkg::ST_EMIT;
      end
      srtf_pkg::ST_EMIT: begin
        if (!out_full) begin
          state_nxt = srtf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srtf_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_pop    = 1'b0;
    out_push  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = arr_slot;
    ram_wrec  = '{rem: item_r.burst, burst: item_r.burst, arr: tick_r};
    ram_re    = 1'b0;
    ram_raddr = run_slot_r;
    unique case (state_r)
      srtf_pkg::ST_IDLE: begin
        in_pop = !in_empty;
      end
      srtf_pkg::ST_ARRIVE: begin
        ram_we = arr_ok;
      end
      srtf_pkg::ST_RET_RD: begin
        ram_re = 1'b1;
      end
      srtf_pkg::ST_SCAN: begin
        ram_re    = (scan_cnt_r < CNT_W'(NUM_SLOTS));
        ram_raddr = scan_cnt_r[SLOT_W-1:0];
      end
      srtf_pkg::ST_UPDATE: begin
        ram_we    = found_r;
        ram_waddr = best_slot_r;
        ram_wrec  = best_rec_r;
        if (best_rec_r.rem != '0) begin
          ram_wrec.rem = best_rec_r.rem - 1'b1;
        end
      end
      srtf_pkg::ST_EMIT: begin
        out_push = !out_full;
      end
      default: begin
      end
    endcase
  end

  assign run_ext  = EXT_W'(best_slot_r);
  assign done_ext = EXT_W'(done_slot_r);

  always_comb begin
    out_res.tick_time       = tick_r;
    out_res.run_valid       = found_r;
    out_res.run_slot        = run_ext[srtf_pkg::SLOT_IN_W-1:0];
    out_res.done_valid      = done_vld_r;
    out_res.done_slot       = done_ext[srtf_pkg::SLOT_IN_W-1:0];
    out_res.turnaround      = turn_r;
    out_res.wait_ticks      = wait_r;
    out_res.arrive_rejected = rej_r;
  end

  // datapath
  always_comb begin
    tick_nxt      = tick_r;
    run_vld_nxt   = run_vld_r;
    run_slot_nxt  = run_slot_r;
    active_nxt    = active_r;
    cmp_vld_nxt   = 1'b0;
    cmp_slot_nxt  = cmp_slot_r;
    scan_cnt_nxt  = scan_cnt_r;
    item_nxt      = item_r;
    rej_nxt       = rej_r;
    done_vld_nxt  = done_vld_r;
    done_slot_nxt = done_slot_r;
    turn_nxt      = turn_r;
    wait_nxt      = wait_r;
    found_nxt     = found_r;
    best_slot_nxt = best_slot_r;
    best_rec_nxt  = best_rec_r;

    // compare the slot whose record returned this cycle
    if (cmp_vld_r && active_r[cmp_slot_r] &&
        (!found_r || rd_rec.rem <= best_rec_r.rem)) begin
      found_nxt     = 1'b1;
      best_slot_nxt = cmp_slot_r;
      best_rec_nxt  = rd_rec;
    end

    unique case (state_r)
      srtf_pkg::ST_IDLE: begin
        item_nxt      = in_item;
        rej_nxt       = 1'b0;
        done_vld_nxt  = 1'b0;
        done_slot_nxt = '0;
        turn_nxt      = '0;
        wait_nxt      = '0;
        found_nxt     = 1'b0;
        best_slot_nxt = '0;
        scan_cnt_nxt  = '0;
      end
      srtf_pkg::ST_ARRIVE: begin
        if (item_r.valid && !arr_ok) begin
          rej_nxt = 1'b1;
        end
        if (arr_ok) begin
          active_nxt[arr_slot] = 1'b1;
        end
      end
      srtf_pkg::ST_RET_TURN: begin
        if (rd_rec.rem == '0) begin
          done_vld_nxt           = 1'b1;
          done_slot_nxt          = run_slot_r;
          turn_nxt               = tick_r - rd_rec.arr;
          active_nxt[run_slot_r] = 1'b0;
          run_vld_nxt            = 1'b0;
        end
      end
      srtf_pkg::ST_RET_WAIT: begin
        wait_nxt = turn_r - srtf_pkg::TICK_W'(rd_rec.burst);
      end
      srtf_pkg::ST_SCAN: begin
        if (scan_cnt_r < CNT_W'(NUM_SLOTS)) begin
          cmp_vld_nxt  = 1'b1;
          cmp_slot_nxt = scan_cnt_r[SLOT_W-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      srtf_pkg::ST_UPDATE: begin
        run_vld_nxt  = found_r;
        run_slot_nxt = found_r ? best_slot_r : '0;
      end
      srtf_pkg::ST_EMIT: begin
        if (!out_full) begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= srtf_pkg::ST_IDLE;
      tick_r     <= '0;
      run_vld_r  <= 1'b0;
      run_slot_r <= '0;
      active_r   <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tick_r     <= tick_nxt;
      run_vld_r  <= run_vld_nxt;
      run_slot_r <= run_slot_nxt;
      active_r   <= active_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_slot_r  <= cmp_slot_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    item_r      <= item_nxt;
    rej_r       <= rej_nxt;
    done_vld_r  <= done_vld_nxt;
    done_slot_r <= done_slot_nxt;
    turn_r      <= turn_nxt;
    wait_r      <= wait_nxt;
    found_r     <= found_nxt;
    best_slot_r <= best_slot_nxt;
    best_rec_r  <= best_rec_nxt;
  end

endmodule

/* hw/rtl/srtf_task_scheduler_top.sv */
// ----------------------------------------------------------------------------
// srtf_task_scheduler_top
// Preemptive shortest-remaining-time-first scheduler, one tick per item.
// ----------------------------------------------------------------------------
// Ticks are handled one at a time: the core pops no new item until the
//   last result is pushed, and its slot scan reads one table entry per cycle.
// Reset: synchronous, active low; clears both queues, the slot active bits,
//   the running task and the tick counter. No clearing pass on the table.
module srtf_task_scheduler_top #(
  parameter int NUM_SLOTS = srtf_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_arrive_valid,
  input  logic [srtf_pkg::SLOT_IN_W-1:0] in_arrive_slot,
  input  logic [srtf_pkg::BURST_W-1:0]   in_arrive_burst,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [srtf_pkg::TICK_W-1:0]    out_tick_time,
  output logic                           out_run_valid,
  output logic [srtf_pkg::SLOT_IN_W-1:0] out_run_slot,
  output logic                           out_done_valid,
  output logic [srtf_pkg::SLOT_IN_W-1:0] out_done_slot,
  output logic [srtf_pkg::TICK_W-1:0]    out_turnaround,
  output logic [srtf_pkg::TICK_W-1:0]    out_wait_ticks,
  output logic                           out_arrive_rejected
);

  srtf_pkg::item_t                   item;
  logic                              q_empty;
  logic                              q_pop;
  logic                              res_full;
  logic                              res_push;
  srtf_pkg::res_t                    res;
  logic [$bits(srtf_pkg::res_t)-1:0] res_rd;
  srtf_pkg::res_t                    res_out;

  srtf_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .full         (in_full),
    .arrive_valid (in_arrive_valid),
    .arrive_slot  (in_arrive_slot),
    .arrive_burst (in_arrive_burst),
    .pop          (q_pop),
    .empty        (q_empty),
    .item         (item)
  );

  srtf_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_empty (q_empty),
    .in_item  (item),
    .in_pop   (q_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_res  (res)
  );

  srtf_fifo #(
    .WIDTH ($bits(srtf_pkg::res_t)),
    .DEPTH (srtf_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd),
    .empty   (out_empty)
  );

  assign res_out             = res_rd;
  assign out_tick_time       = res_out.tick_time;
  assign out_run_valid       = res_out.run_valid;
  assign out_run_slot        = res_out.run_slot;
  assign out_done_valid      = res_out.done_valid;
  assign out_done_slot       = res_out.done_slot;
  assign out_turnaround      = res_out.turnaround;
  assign out_wait_ticks      = res_out.wait_ticks;
  assign out_arrive_rejected = res_out.arrive_rejected;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives scheduler ticks through the input queue with random gaps and pops
// results with random stalls. A scoreboard class keeps its own copy of the
// slot table and predicts every tick: arrivals and rejects, retirement with
// turnaround and wait, and the least-remaining pick with ties to the top slot.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS        = srtf_pkg::NUM_SLOTS_DEF;
  localparam int TICK_W       = srtf_pkg::TICK_W;
  localparam int BURST_W      = srtf_pkg::BURST_W;
  localparam int SLOT_IN_W    = srtf_pkg::SLOT_IN_W;
  localparam int RANDOM_TICKS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;

  class srtf_scoreboard;
    bit [BURST_W-1:0]   rem_left [SLOTS];
    bit [BURST_W-1:0]   burst_of [SLOTS];
    bit [TICK_W-1:0]    arrived_at [SLOTS];
    bit                 active [SLOTS];
    bit [SLOT_IN_W-1:0] running_slot;
    bit                 running;
    bit [TICK_W-1:0]    now_tick;
    srtf_pkg::res_t     ticks_due[$];
    int                 fail_count;

    function int pending();
      return ticks_due.size();
    endfunction

    // predict one accepted tick
    function void note_tick(bit a_valid, bit [SLOT_IN_W-1:0] a_slot,
                            bit [BURST_W-1:0] a_burst);
      srtf_pkg::res_t want;
      int   best;
      bit   found;
      int   s;
      want = '0;
      want.tick_time = now_tick;
      if (a_valid) begin
        if (a_slot >= SLOTS || active[a_slot]) begin
          want.arrive_rejected = 1'b1;
        end else begin
          rem_left[a_slot]   = a_burst;
          burst_of[a_slot]   = a_burst;
          arrived_at[a_slot] = now_tick;
          active[a_slot]     = 1'b1;
        end
      end
      if (running && active[running_slot] && rem_left[running_slot] == '0) begin
        want.done_valid = 1'b1;
        want.done_slot  = running_slot;
        want.turnaround = now_tick - arrived_at[running_slot];
        want.wait_ticks = want.turnaround - TICK_W'(burst_of[running_slot]);
        active[running_slot] = 1'b0;
        running = 1'b0;
      end
      found = 1'b0;
      best  = 0;
      for (s = 0; s < SLOTS; s++) begin
        if (active[s] && (!found || rem_left[s] <= rem_left[best])) begin
          best  = s;
          found = 1'b1;
        end
      end
      if (found) begin
        running_slot = SLOT_IN_W'(best);
        running      = 1'b1;
        if (rem_left[best] != '0) rem_left[best] = rem_left[best] - 1'b1;
        want.run_valid = 1'b1;
        want.run_slot  = SLOT_IN_W'(best);
      end else begin
        running      = 1'b0;
        running_slot = '0;
      end
      now_tick = now_tick + 1'b1;
      ticks_due.push_back(want);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        fail_count++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_tick(srtf_pkg::res_t got);
      srtf_pkg::res_t want;
      if (ticks_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none actual %p", $time, got);
        return;
      end
      want = ticks_due.pop_front();
      check_field("tick_time", want.tick_time, got.tick_time);
      check_field("run_valid", want.run_valid, got.run_valid);
      check_field("run_slot", want.run_slot, got.run_slot);
      check_field("done_valid", want.done_valid, got.done_valid);
      check_field("done_slot", want.done_slot, got.done_slot);
      check_field("turnaround", want.turnaround, got.turnaround);
      check_field("wait_ticks", want.wait_ticks, got.wait_ticks);
      check_field("arrive_rejected", want.arrive_rejected, got.arrive_rejected);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic                 in_arrive_valid;
  logic [SLOT_IN_W-1:0] in_arrive_slot;
  logic [BURST_W-1:0]   in_arrive_burst;
  logic                 out_empty;
  logic                 out_pop;
  logic [TICK_W-1:0]    out_tick_time;
  logic                 out_run_valid;
  logic [SLOT_IN_W-1:0] out_run_slot;
  logic                 out_done_valid;
  logic [SLOT_IN_W-1:0] out_done_slot;
  logic [TICK_W-1:0]    out_turnaround;
  logic [TICK_W-1:0]    out_wait_ticks;
  logic                 out_arrive_rejected;

  srtf_scoreboard sched = new();
  bit             calm_in;
  bit             calm_out;
  int unsigned    cycles = 0;

  srtf_task_scheduler_top #(
    .NUM_SLOTS(SLOTS)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_arrive_valid    (in_arrive_valid),
    .in_arrive_slot     (in_arrive_slot),
    .in_arrive_burst    (in_arrive_burst),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_tick_time      (out_tick_time),
    .out_run_valid      (out_run_valid),
    .out_run_slot       (out_run_slot),
    .out_done_valid     (out_done_valid),
    .out_done_slot      (out_done_slot),
    .out_turnaround     (out_turnaround),
    .out_wait_ticks     (out_wait_ticks),
    .out_arrive_rejected(out_arrive_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // hold push until the tick transfers, then predict it
  task automatic send_tick(bit v, bit [SLOT_IN_W-1:0] s, bit [BURST_W-1:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_arrive_valid <= v;
    in_arrive_slot  <= s;
    in_arrive_burst <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sched.note_tick(v, s, b);
  endtask

  task automatic send_random_tick(int arrive_pct);
    bit                 v;
    bit [SLOT_IN_W-1:0] s;
    bit [BURST_W-1:0]   b;
    int                 p;
    int                 i;
    bit [SLOT_IN_W-1:0] free_slots[$];
    v = ($urandom_range(0, 99) < arrive_pct);
    s = SLOT_IN_W'($urandom_range(0, 7));
    p = $urandom_range(0, 99);
    if (p == 0) b = BURST_W'($urandom);
    else if (p < 11) b = BURST_W'($urandom_range(7, 40));
    else b = BURST_W'($urandom_range(0, 6));
    // steer most arrivals into free slots
    if (v && $urandom_range(0, 3) != 0) begin
      for (i = 0; i < SLOTS; i++) begin
        if (!sched.active[i]) free_slots.push_back(SLOT_IN_W'(i));
      end
      if (free_slots.size() > 0) s = free_slots[$urandom_range(0, free_slots.size() - 1)];
    end
    send_tick(v, s, b);
  endtask

  initial begin
    int k;
    int arrive_pct;
    rst_n           <= 1'b0;
    in_push         <= 1'b0;
    in_arrive_valid <= 1'b0;
    in_arrive_slot  <= '0;
    in_arrive_burst <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(1'b0, 3'd0, 16'h0000);
    send_tick(1'b0, 3'd7, 16'hffff);
    send_tick(1'b1, 3'd0, 16'h0000);
    send_tick(1'b0, 3'd0, 16'h0000);
    send_tick(1'b1, 3'd7, 16'hffff);
    send_tick(1'b1, 3'd7, 16'h0005);
    send_tick(1'b1, 3'd3, 16'h0003);
    send_tick(1'b1, 3'd5, 16'h0002);
    send_tick(1'b0, 3'd0, 16'h0000);
    send_tick(1'b1, 3'd1, 16'h0000);
    send_tick(1'b1, 3'd2, 16'h0000);
    send_tick(1'b1, 3'd6, 16'h0001);
    send_tick(1'b1, 3'd4, 16'h8000);
    send_tick(1'b1, 3'd4, 16'h0001);
    repeat (8) send_tick(1'b0, 3'd0, 16'h0000);

    arrive_pct = 30;
    for (k = 0; k < RANDOM_TICKS; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: arrive_pct = 15;
          1: arrive_pct = 35;
          default: arrive_pct = 60;
        endcase
      end
      send_random_tick(arrive_pct);
    end
    in_push <= 1'b0;

    while (sched.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sched.fail_count == 0 && sched.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // pop results with random stalls and check each transfer
  initial begin
    int             gap;
    srtf_pkg::res_t got;
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      gap = calm_out ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      got.tick_time       = out_tick_time;
      got.run_valid       = out_run_valid;
      got.run_slot        = out_run_slot;
      got.done_valid      = out_done_valid;
      got.done_slot       = out_done_slot;
      got.turnaround      = out_turnaround;
      got.wait_ticks      = out_wait_ticks;
      got.arrive_rejected = out_arrive_rejected;
      sched.check_tick(got);
    end
  end

endmodule

/* srtf_task_scheduler_top.f */
hw/rtl/srtf_pkg.sv
hw/rtl/srtf_ram.sv
hw/rtl/srtf_fifo.sv
hw/rtl/srtf_front.sv
hw/rtl/srtf_back.sv
hw/rtl/srtf_task_scheduler_top.sv
tb/testbench.sv
